>>> sv/window_median_even_average_core_defines.svh
// assertion macros for the window median core
// no dependencies; included by files that carry concurrent checks
`ifndef WINDOW_MEDIAN_EVEN_AVERAGE_CORE_DEFINES_SVH
`define WINDOW_MEDIAN_EVEN_AVERAGE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WMEA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wmea assertion failed");
`define WMEA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wmea forbidden condition seen");
`else
`define WMEA_ASSERT(lbl, prop)
`define WMEA_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> sv/wmea_pkg.sv
// shared types and constants for the window median core
// no dependencies
`timescale 1ns / 1ps
package wmea_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int CNT_OUT_W       = 5;
  localparam int MAX_SAMPLES_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // one queued transaction, tagged by the front with whether it fits in the store
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                keep;
  } item_t;

  typedef enum logic [0:0] {
    BK_FILL = 1'b0,
    BK_PICK = 1'b1
  } back_state_e;

endpackage

>>> sv/wmea_front.sv
// front end: takes transactions, classifies keep or drop, buffers them in a short queue
// depends on wmea_pkg
`timescale 1ns / 1ps
module wmea_front import wmea_pkg::*; #(
  parameter int MaxSamples = MAX_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  output logic                full_o,
  output logic                q_vld_o,
  output item_t               q_item_o,
  input  logic                q_pop_i
);

  localparam int CNT_W = $clog2(MaxSamples + 1);

  item_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]    seen_q, seen_d;
  logic                keep;
  item_t               new_item;

  // samples in this set that will find room in the store
  assign keep = (seen_q < CNT_W'(MaxSamples));

  always_comb begin
    new_item.sample = sample_i;
    new_item.last   = last_i;
    new_item.keep   = keep;
  end

  always_comb begin
    seen_d = seen_q;
    if (push_i) begin
      if (last_i) begin
        seen_d = '0;
      end else if (keep) begin
        seen_d = seen_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !q_pop_i) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (!push_i && q_pop_i) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      seen_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  assign full_o   = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign q_vld_o  = (fill_q != '0);
  assign q_item_o = queue_q[rd_ptr_q];

endmodule

>>> sv/wmea_back.sv
// back end: insertion chain keeping the set sorted, then median pick and averaging
// depends on wmea_pkg
`timescale 1ns / 1ps
module wmea_back import wmea_pkg::*; #(
  parameter int MaxSamples = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_vld_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output logic                 valid_o,
  output logic [SAMPLE_W-1:0]  median_value_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  output logic                 overflow_o
);

  localparam int CNT_W = $clog2(MaxSamples + 1);
  localparam int IDX_W = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int EXT_W = CNT_W + CNT_OUT_W;

  back_state_e         st_q, st_d;
  logic [SAMPLE_W-1:0] store_q [MaxSamples];
  logic [SAMPLE_W-1:0] store_d [MaxSamples];
  logic [MaxSamples-1:0] gt;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                drop_q, drop_d;
  logic                ins;
  logic [CNT_W-1:0]    mid, mid_m1;

  // pick stage
  logic                pair_vld_q;
  logic [SAMPLE_W-1:0] lo_q, hi_q;
  logic                odd_q, pdrop_q;
  logic [CNT_W-1:0]    pcnt_q;

  // output stage
  logic                out_vld_q;
  logic [SAMPLE_W-1:0] out_val_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic                out_ovf_q;
  logic [SAMPLE_W:0]   pair_sum, pair_adj;
  logic [EXT_W-1:0]    cnt_ext;

  assign q_pop_o = q_vld_i && (st_q == BK_FILL);
  assign ins     = q_pop_o && q_item_i.keep;

  // empty slots count as greater so the new sample lands at the first one
  for (genvar i = 0; i < MaxSamples; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= cnt_q) ||
                   ($signed(store_q[i]) > $signed(q_item_i.sample));
    if (i == 0) begin : g_head
      assign store_d[i] = gt[i] ? q_item_i.sample : store_q[i];
    end else begin : g_body
      assign store_d[i] = !gt[i]    ? store_q[i]   :
                          gt[i - 1] ? store_q[i-1] : q_item_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      store_q <= store_d;
    end
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    unique case (st_q)
      BK_FILL: begin
        if (q_pop_o) begin
          if (q_item_i.keep) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (q_item_i.last) begin
            st_d = BK_PICK;
          end
        end
      end
      BK_PICK: begin
        cnt_d  = '0;
        drop_d = 1'b0;
        st_d   = BK_FILL;
      end
      default: st_d = BK_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_FILL;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

  assign mid    = cnt_q >> 1;
  assign mid_m1 = mid - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_vld_q <= 1'b0;
    end else begin
      pair_vld_q <= (st_q == BK_PICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_PICK) begin
      hi_q    <= store_q[mid[IDX_W-1:0]];
      lo_q    <= store_q[mid_m1[IDX_W-1:0]];
      odd_q   <= cnt_q[0];
      pcnt_q  <= cnt_q;
      pdrop_q <= drop_q;
    end
  end

  // mean of the centre pair, rounded toward zero
  assign pair_sum = {lo_q[SAMPLE_W-1], lo_q} + {hi_q[SAMPLE_W-1], hi_q};
  assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
  assign cnt_ext  = EXT_W'(pcnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= pair_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_vld_q) begin
      out_val_q <= odd_q ? hi_q : pair_adj[SAMPLE_W:1];
      out_cnt_q <= cnt_ext[CNT_OUT_W-1:0];
      out_ovf_q <= pdrop_q;
    end
  end

  assign valid_o        = out_vld_q;
  assign median_value_o = out_val_q;
  assign sample_count_o = out_cnt_q;
  assign overflow_o     = out_ovf_q;

endmodule

>>> sv/window_median_even_average_core.sv
// window median core: keeps a set of signed samples sorted and gives its median
// depends on wmea_pkg, wmea_front, wmea_back and the assertion macro header
//
// usage:
//   a sample is taken at a rising edge with start high and busy low; last_i
//   marks the final sample of a set. one result per set: valid_o is high for a
//   single cycle with median_value_o, sample_count_o and overflow_o.
//   an odd set gives its middle value, an even set the mean of the centre pair
//   rounded toward zero. samples past MaxSamples are dropped and set overflow_o.
// timing:
//   a two-entry queue sits between the front and the sorting back end. the
//   insertion chain places one sample per cycle, so input is taken at one
//   sample per cycle while busy is low; after each final sample the back end
//   spends its pick state on the centre pair, and busy rises when the queue fills.
//   with the queue empty, the final sample passes the queue entry, the pick
//   state, the pick registers and the averaging register before valid_o rises.
// reset:
//   rst_ni clears the queue, the fill count and the overflow flag; the store
//   itself holds no reset value and needs no clearing pass.
//   the receiver has no way to hold results off; each result stands one cycle.
`timescale 1ns / 1ps
`include "window_median_even_average_core_defines.svh"
module window_median_even_average_core import wmea_pkg::*; #(
  parameter int MaxSamples = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 last_i,
  output logic                 valid_o,
  output logic [SAMPLE_W-1:0]  median_value_o,
  output logic [CNT_OUT_W-1:0] sample_count_o,
  output logic                 overflow_o
);

  logic  push;
  logic  q_vld;
  logic  q_pop;
  item_t q_item;

  assign push = start && !busy;

  wmea_front #(.MaxSamples(MaxSamples)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (sample_i),
    .last_i   (last_i),
    .full_o   (busy),
    .q_vld_o  (q_vld),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  wmea_back #(.MaxSamples(MaxSamples)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_vld_i        (q_vld),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .valid_o        (valid_o),
    .median_value_o (median_value_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  // the pick cycle always separates two results
  `WMEA_ASSERT(a_result_spacing, valid_o |=> !valid_o)
  `WMEA_ASSERT_NEVER(a_pop_empty, q_pop && !q_vld)
  `WMEA_ASSERT(a_overflow_full, (valid_o && overflow_o) |-> (sample_count_o == CNT_OUT_W'(MaxSamples)))

endmodule

>>> bench/window_median_even_average_core_tb.sv
// testbench for window_median_even_average_core: directed and random sample sets
// checked against an in-bench sorted-store median predictor; depends on wmea_pkg
`timescale 1ns / 1ps
module window_median_even_average_core_tb;
  import wmea_pkg::*;

  localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] median;
    logic [CNT_OUT_W-1:0]       count;
    logic                       overflow;
  } median_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [SAMPLE_W-1:0]  sample_i;
  logic                 last_i;
  logic                 valid_o;
  logic [SAMPLE_W-1:0]  median_value_o;
  logic [CNT_OUT_W-1:0] sample_count_o;
  logic                 overflow_o;

  // predictor state
  logic signed [SAMPLE_W-1:0] sorted_set[STORE_DEPTH];
  int                         set_fill;
  logic                       set_dropped;
  median_result_t             pending_medians[$];
  median_result_t             got_median;

  int  mismatch_count;
  int  stall_cycles;
  bit  gaps_on;

  window_median_even_average_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .valid_o        (valid_o),
    .median_value_o (median_value_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // insert one accepted sample; on the final one, form the expected median
  task automatic predict_median(input logic signed [SAMPLE_W-1:0] v, input logic fin);
    int             pos;
    int             mid;
    longint         pair_sum;
    median_result_t r;
    if (set_fill < STORE_DEPTH) begin
      pos = set_fill;
      while (pos > 0 && sorted_set[pos-1] > v) begin
        sorted_set[pos] = sorted_set[pos-1];
        pos--;
      end
      sorted_set[pos] = v;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (fin) begin
      mid = set_fill >> 1;
      if (set_fill % 2 == 1) begin
        r.median = sorted_set[mid];
      end else begin
        pair_sum = longint'(sorted_set[mid]) + longint'(sorted_set[mid-1]);
        r.median = SAMPLE_W'(pair_sum / 2);
      end
      r.count    = CNT_OUT_W'(set_fill);
      r.overflow = set_dropped;
      pending_medians.push_back(r);
      set_fill    = 0;
      set_dropped = 1'b0;
    end
  endtask

  // drive one sample and hold it until the transaction is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic fin);
    if (gaps_on && $urandom_range(99) < 34) begin
      start    <= 1'b0;
      sample_i <= $urandom;
      last_i   <= 1'($urandom_range(1));
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= v;
    last_i   <= fin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_median(v, fin);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(5))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = S_MAX - 1;
          3: v = S_MIN + 1;
          4: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // sender holds off until every expected result is out
  task automatic drain_results();
    start <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
  endtask

  function automatic int rand_set_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1);
    if (r < 20) return 1;
    return $urandom_range(STORE_DEPTH, 1);
  endfunction

  task automatic test_extremes();
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b1);
    // even sets whose pair sum needs the 33rd bit
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b1);
    // odd negative pair sums truncate toward zero, then a mixed-sign pair with an even sum
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(0, 1'b1);
    send_sample(3, 1'b0);
    send_sample(-1, 1'b1);
    // equal samples side by side, one of them arriving after a smaller sample
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(5, 1'b1);
    drain_results();
  endtask

  task automatic test_full_store();
    send_set(STORE_DEPTH);
    send_set(STORE_DEPTH - 1);
    // final sample meets a full store and is dropped
    send_set(STORE_DEPTH + 1);
    send_set(2 * STORE_DEPTH);
    send_set(STORE_DEPTH);
    drain_results();
  endtask

  task automatic test_back_to_back();
    int sent;
    gaps_on = 1'b0;
    sent = 0;
    while (sent < 250) begin
      // runs of single-sample sets keep the pick stage busy
      if ($urandom_range(3) == 0) begin
        repeat (8) send_sample(rand_sample(), 1'b1);
        sent += 8;
      end else begin
        automatic int len = rand_set_len();
        send_set(len);
        sent += len;
      end
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    sent = 0;
    while (sent < 850) begin
      len = rand_set_len();
      send_set(len);
      sent += len;
      if ($urandom_range(19) == 0) drain_results();
    end
  endtask

  // result check: each strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_medians.size() == 0) begin
        $display("unexpected result at %0t: median %0h", $realtime, median_value_o);
        mismatch_count++;
      end else begin
        got_median = pending_medians.pop_front();
        if (median_value_o !== got_median.median)
          report_mismatch("median_value", median_value_o, got_median.median);
        if (sample_count_o !== got_median.count)
          report_mismatch("sample_count", SAMPLE_W'(sample_count_o),
                          SAMPLE_W'(got_median.count));
        if (overflow_o !== got_median.overflow)
          report_mismatch("overflow", SAMPLE_W'(overflow_o),
                          SAMPLE_W'(got_median.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    sample_i       = '0;
    last_i         = 1'b0;
    set_fill       = 0;
    set_dropped    = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    gaps_on        = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_full_store();
    test_back_to_back();
    test_random_sets();

    start <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_medians.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/wmea_pkg.sv
sv/wmea_front.sv
sv/wmea_back.sv
sv/window_median_even_average_core.sv
bench/window_median_even_average_core_tb.sv
